/* rtl/core/egc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// egc_pkg
// Shared types and codes for the elevator group controller.
// ---------------------------------------------------------------------------
package egc_pkg;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_HALL = 2'd1,
    KIND_CAR  = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  localparam logic [1:0] MOT_STOP = 2'd0;
  localparam logic [1:0] MOT_UP   = 2'd1;
  localparam logic [1:0] MOT_DOWN = 2'd2;

  localparam logic [1:0] HALL_NONE = 2'd0;

  localparam logic [0:0] CFG_NUM_FLOORS = 1'b0;
  localparam logic [0:0] CFG_NUM_CARS   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_HALL_SCAN,
    ST_HALL_WR,
    ST_CAR_WR,
    ST_CALL_WB,
    ST_TK_LOAD,
    ST_TK_HSCAN,
    ST_TK_DSCAN,
    ST_TK_RDPOS,
    ST_TK_SERVE,
    ST_TK_ARRIVE,
    ST_TK_OUT
  } state_e;

endpackage
`default_nettype wire

/* rtl/core/elevator_group_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// elevator_group_controller
// Dispatches hall and car calls to a group of cars and steps them on ticks.
// ---------------------------------------------------------------------------
// A tick steps each car in use in turn, walking its table row floor by floor,
// with one result strobed as each car finishes; a hall call scans the cars
// in use before it updates the table, a car call only updates it, an ignored item
// leaves busy low. One item at a time; the floor-by-floor table walk sets the rate.
// Reset: cars at floor one and stopped, 20 floors and 6 cars, then a clearing
// pass over every table entry with busy high. No result stall.
// ---------------------------------------------------------------------------
module elevator_group_controller
  import egc_pkg::*;
#(
  parameter int MAX_FLOORS = 20,
  parameter int MAX_CARS   = 6
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] kind_i,
  input  wire logic [4:0] floor_i,
  input  wire logic       direction_i,
  input  wire logic [2:0] car_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [4:0] cfg_data_i,
  output logic            result_valid_o,
  output logic [2:0]      car_number_o,
  output logic [4:0]      position_o,
  output logic [1:0]      motion_o,
  output logic            boarded_o,
  output logic            delivered_o,
  output logic            last_o
);

  localparam int FW    = $clog2(MAX_FLOORS + 1);
  localparam int CW    = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
  localparam int DEPTH = MAX_CARS * (MAX_FLOORS + 1);
  localparam int AW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(MAX_CARS + 1);
  localparam logic [FW-1:0] MAXF = FW'(MAX_FLOORS);

  // Table memory: entry {destination, hall[1:0]} per car and floor.
  logic [2:0] mem_q [DEPTH];
  logic [AW-1:0] raddr, waddr;
  logic [2:0] rdata_q, wdata;
  logic we;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  function automatic logic [AW-1:0] addr_of(logic [CW-1:0] c, logic [FW-1:0] f);
    addr_of = AW'(c * (MAX_FLOORS + 1) + f);
  endfunction

  // Car state registers (small, one per car).
  logic [FW-1:0] pos_q [MAX_CARS];
  logic [1:0]    mot_q [MAX_CARS];

  state_e state_q, state_d;
  logic [4:0] nf_q;
  logic [2:0] nc_q;
  logic [AW-1:0] clr_q, clr_d;
  logic [FW-1:0] f_q, f_d;       // floor whose entry is in rdata_q
  logic [CW-1:0] c_q, c_d;       // current car
  logic [FW-1:0] fl_q;           // latched call floor
  logic [1:0] want_q;
  logic [CW-1:0] car_q;
  logic wr_hall_q;
  logic [FW-1:0] best_q, best_d;
  logic [CW-1:0] ch_q, ch_d;
  logic [1:0] mot_d, motw_q;     // working motion of current car
  logic own_dest_q, own_dest_d;
  logic b_q, b_d, dl_q, dl_d;
  logic [FW-1:0] p_q, p_d;

  // Effective register values: clamp into the legal range.
  logic [FW-1:0] nf;
  logic [CNTW-1:0] nc;
  always_comb begin
    if (nf_q == 5'd0) nf = FW'(1);
    else if (32'(nf_q) > MAX_FLOORS) nf = MAXF;
    else nf = FW'(nf_q);
    if (nc_q == 3'd0) nc = CNTW'(1);
    else if (32'(nc_q) > MAX_CARS) nc = CNTW'(MAX_CARS);
    else nc = CNTW'(nc_q);
  end

  // Call floor must lie within the floors in use; drop the call otherwise.
  logic floor_ok;
  assign floor_ok = (floor_i != 5'd0) && (32'(floor_i) <= 32'(nf));

  logic [FW-1:0] fl_in;
  assign fl_in = FW'(floor_i);

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_q != ST_IDLE);
  // Take register writes only between items.
  assign cfg_ready_o = (state_q == ST_IDLE);

  // Hall dispatch: distance of current car to the call floor.
  logic [FW-1:0] gap;
  logic [FW-1:0] pc;
  assign pc = pos_q[c_q];
  assign gap = (pc > fl_q) ? pc - fl_q : fl_q - pc;

  logic last_car;
  assign last_car = (CNTW'(c_q) + CNTW'(1) == nc);

  // One-floor move of the current car; hold and stop at either end.
  logic [FW-1:0] p_step;
  logic end_stop;
  always_comb begin
    if (motw_q == MOT_DOWN) begin
      end_stop = (p_q <= FW'(1));
      p_step = end_stop ? p_q : p_q - FW'(1);
    end else begin
      end_stop = (p_q >= nf);
      p_step = end_stop ? p_q : p_q + FW'(1);
    end
  end

  // Merge a call into the entry read back from the table.
  logic [2:0] merged;
  always_comb begin
    if (wr_hall_q) merged = {rdata_q[2], want_q};
    else merged = {1'b1, rdata_q[1:0]};
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    f_d = f_q;
    c_d = c_q;
    best_d = best_q;
    ch_d = ch_q;
    mot_d = motw_q;
    own_dest_d = own_dest_q;
    b_d = b_q;
    dl_d = dl_q;
    p_d = p_q;
    raddr = addr_of(c_q, f_q);
    waddr = clr_q;
    wdata = 3'b000;
    we = 1'b0;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_e'(kind_i))
            KIND_HALL: begin
              if (floor_ok) begin
                c_d = '0;
                best_d = MAXF;
                ch_d = '0;
                state_d = ST_HALL_SCAN;
              end
            end
            KIND_CAR: begin
              if (floor_ok && 32'(car_i) < 32'(nc)) begin
                state_d = ST_CAR_WR;
              end
            end
            KIND_TICK: begin
              c_d = '0;
              state_d = ST_TK_LOAD;
            end
            default: ;
          endcase
        end
      end
      ST_CLEAR: begin
        // Empty the table, destination and hall marks alike, one entry per cycle.
        we = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (32'(clr_q) == DEPTH - 1) state_d = ST_IDLE;
      end
      ST_HALL_SCAN: begin
        // Keep the nearest stopped or same-direction car; lower number wins ties.
        if (gap < best_q && (mot_q[c_q] == want_q || mot_q[c_q] == MOT_STOP)) begin
          best_d = gap;
          ch_d = c_q;
        end
        if (last_car) state_d = ST_HALL_WR;
        else c_d = c_q + CW'(1);
      end
      ST_HALL_WR: begin
        // car_q takes the chosen car at this edge.
        state_d = ST_CAR_WR;
      end
      ST_CAR_WR: begin
        raddr = addr_of(car_q, fl_q);
        state_d = ST_CALL_WB;
      end
      ST_CALL_WB: begin
        we = 1'b1;
        waddr = addr_of(car_q, fl_q);
        wdata = merged;
        state_d = ST_IDLE;
      end
      ST_TK_LOAD: begin
        mot_d = mot_q[c_q];
        p_d = pos_q[c_q];
        b_d = 1'b0;
        dl_d = 1'b0;
        f_d = FW'(1);
        raddr = addr_of(c_q, FW'(1));
        state_d = ST_TK_HSCAN;
      end
      ST_TK_HSCAN: begin
        // A stopped car starts toward the first pending hall call.
        if (motw_q == MOT_STOP && rdata_q[1:0] != HALL_NONE) begin
          mot_d = (f_q > p_q) ? MOT_UP : MOT_DOWN;
        end
        if (f_q >= nf) begin
          raddr = addr_of(c_q, p_q);
          state_d = ST_TK_RDPOS;
        end else begin
          raddr = addr_of(c_q, f_q + FW'(1));
          f_d = f_q + FW'(1);
        end
      end
      ST_TK_RDPOS: begin
        // rdata_q holds the entry at the car's own floor.
        own_dest_d = rdata_q[2];
        f_d = FW'(1);
        raddr = addr_of(c_q, FW'(1));
        state_d = ST_TK_DSCAN;
      end
      ST_TK_DSCAN: begin
        // Still stopped: head for a destination with no hall call there.
        if (rdata_q[2] && rdata_q[1:0] == HALL_NONE && !own_dest_q &&
            motw_q == MOT_STOP) begin
          mot_d = (f_q > p_q) ? MOT_UP : MOT_DOWN;
        end
        if (f_q >= nf) begin
          raddr = addr_of(c_q, p_q);
          state_d = ST_TK_SERVE;
        end else begin
          raddr = addr_of(c_q, f_q + FW'(1));
          f_d = f_q + FW'(1);
        end
      end
      ST_TK_SERVE: begin
        waddr = addr_of(c_q, p_q);
        if (motw_q == MOT_STOP) begin
          // Serve both calls at this floor; the entry ends empty.
          we = 1'b1;
          wdata = 3'b000;
          b_d = (rdata_q[1:0] != HALL_NONE);
          dl_d = rdata_q[2];
          state_d = ST_TK_OUT;
        end else if (rdata_q[1:0] != HALL_NONE) begin
          // Stop for the hall call and keep the destination mark.
          we = 1'b1;
          wdata = {rdata_q[2], HALL_NONE};
          mot_d = MOT_STOP;
          b_d = 1'b1;
          state_d = ST_TK_OUT;
        end else begin
          p_d = p_step;
          if (end_stop) mot_d = MOT_STOP;
          raddr = addr_of(c_q, p_step);
          state_d = ST_TK_ARRIVE;
        end
      end
      ST_TK_ARRIVE: begin
        // Stop on a destination at the new floor.
        if (rdata_q[2]) mot_d = MOT_STOP;
        state_d = ST_TK_OUT;
      end
      ST_TK_OUT: begin
        result_valid_o = 1'b1;
        if (last_car) state_d = ST_IDLE;
        else begin
          c_d = c_q + CW'(1);
          state_d = ST_TK_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign car_number_o = 3'(c_q);
  assign position_o   = 5'(p_q);
  assign motion_o     = motw_q;
  assign boarded_o    = b_q;
  assign delivered_o  = dl_q;
  assign last_o       = last_car;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      nf_q <= 5'd20;
      nc_q <= 3'd6;
      clr_q <= '0;
      f_q <= '0;
      c_q <= '0;
      motw_q <= MOT_STOP;
      for (int i = 0; i < MAX_CARS; i++) begin
        pos_q[i] <= FW'(1);
        mot_q[i] <= MOT_STOP;
      end
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      f_q <= f_d;
      c_q <= c_d;
      motw_q <= mot_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_NUM_FLOORS) nf_q <= cfg_data_i;
        else if (cfg_index_i == CFG_NUM_CARS) nc_q <= cfg_data_i[2:0];
      end
      // A stopped car that takes a call starts toward it.
      if (state_q == ST_CAR_WR && mot_q[car_q] == MOT_STOP) begin
        mot_q[car_q] <= (fl_q > pos_q[car_q]) ? MOT_UP : MOT_DOWN;
      end
      if (state_q == ST_TK_OUT) begin
        mot_q[c_q] <= motw_q;
        pos_q[c_q] <= p_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    ch_q <= ch_d;
    own_dest_q <= own_dest_d;
    b_q <= b_d;
    dl_q <= dl_d;
    p_q <= p_d;
    if (accept) begin
      fl_q <= fl_in;
      car_q <= CW'(car_i);
      wr_hall_q <= (kind_i == KIND_HALL);
      if (fl_in == FW'(1)) want_q <= MOT_UP;
      else if (fl_in == nf) want_q <= MOT_DOWN;
      else want_q <= direction_i ? MOT_DOWN : MOT_UP;
    end else if (state_q == ST_HALL_WR) begin
      car_q <= ch_q;
    end
  end

endmodule
`default_nettype wire
